[rtl/core/hcfb_pkg.sv]
// Shared types, constants and the key code table of the HID command frame builder.
package hcfb_pkg;

  localparam logic [1:0] FUNC_KBD = 2'd0;
  localparam logic [1:0] FUNC_REL = 2'd1;
  localparam logic [1:0] FUNC_ABS = 2'd2;
  localparam logic [1:0] FUNC_NONE = 2'd3;

  localparam logic [7:0] SYNC_0 = 8'h57;
  localparam logic [7:0] SYNC_1 = 8'hAB;
  localparam logic [7:0] ADDR_BYTE = 8'h00;

  localparam logic [7:0] CMD_KBD = 8'h02;
  localparam logic [7:0] CMD_ABS = 8'h04;
  localparam logic [7:0] CMD_REL = 8'h05;

  localparam logic [7:0] LEN_KBD = 8'h08;
  localparam logic [7:0] LEN_REL = 8'h05;
  localparam logic [7:0] LEN_ABS = 8'h07;

  localparam logic [7:0] MODE_REL = 8'h01;
  localparam logic [7:0] MODE_ABS = 8'h02;

  localparam logic [3:0] FRAME_LEN_KBD = 4'd14;
  localparam logic [3:0] FRAME_LEN_REL = 4'd11;
  localparam logic [3:0] FRAME_LEN_ABS = 4'd13;

  localparam int KEY_COUNT = 6;
  localparam int DIV_STEPS = 6;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [15:0] SCREEN_WIDTH_RESET = 16'd1920;
  localparam logic [15:0] SCREEN_HEIGHT_RESET = 16'd1080;

  localparam logic [2:0] REG_SCREEN_WIDTH = 3'd0;
  localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd4;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] buttons;
    logic [KEY_COUNT-1:0][7:0] usage;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [7:0] wheel;
  } cmd_t;

  function automatic logic [7:0] key_usage(input logic [7:0] c);
    logic [7:0] u;
    u = 8'h00;
    if (c >= 8'h21 && c <= 8'h24) begin
      u = c + 8'h07;
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      u = c - 8'h3D;
    end else if (c >= 8'h31 && c <= 8'h39) begin
      u = c - 8'h13;
    end else if (c > 8'h60) begin
      u = c - 8'h28;
    end else begin
      case (c)
        8'h30: u = 8'h27;
        8'h20: u = 8'h2C;
        8'h2D: u = 8'h2D;
        8'h3D: u = 8'h2E;
        8'h5B: u = 8'h2F;
        8'h5D: u = 8'h30;
        8'h5C: u = 8'h31;
        8'h3B: u = 8'h33;
        8'h27: u = 8'h34;
        8'h60: u = 8'h35;
        8'h2C: u = 8'h36;
        8'h2E: u = 8'h37;
        8'h2F: u = 8'h38;
        default: u = 8'h00;
      endcase
    end
    return u;
  endfunction

endpackage

[rtl/core/hid_command_frame_builder_core.sv]
// Top level of the serial HID command frame builder with its register port.
//
// A command request enters on in_valid/in_ready with its kind, button byte,
// six key codes, two positions and wheel. The block answers with the serial
// frame on out_valid/out_ready, one byte per transfer on that channel, and
// raises last_byte on the closing checksum byte. Keyboard frames are 14
// bytes, relative mouse frames 11 and absolute mouse frames 13; kind 3 is
// taken and produces nothing. A command passes the front register and the
// queue, and the back stage offers the first byte from its output register.
// With out_ready held high the output runs one byte per cycle and frames
// follow without a gap while commands are queued; frame length sets the rate.
// Absolute coordinates come from two dividers that resolve two quotient
// bits a cycle and finish before the coordinate bytes are due.
// The APB port holds the screen width at address 0 and height at address 4.
// Reset empties the queue, drops any frame in flight and restores 1920 by
// 1080. When the receiver stalls, the current byte holds and commands queue
// up until in_ready falls.
module hid_command_frame_builder_core #(
  parameter int QUEUE_DEPTH = hcfb_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        func,
  input  logic [7:0]        buttons,
  input  logic [7:0]        key_0,
  input  logic [7:0]        key_1,
  input  logic [7:0]        key_2,
  input  logic [7:0]        key_3,
  input  logic [7:0]        key_4,
  input  logic [7:0]        key_5,
  input  logic [15:0]       pos_x,
  input  logic [15:0]       pos_y,
  input  logic signed [7:0] wheel,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        frame_byte,
  output logic              last_byte,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [15:0] screen_width;
  logic [15:0] screen_height;
  logic cfg_write;
  logic q_push;
  logic q_ready;
  logic q_pop;
  logic q_valid;
  hcfb_pkg::cmd_t fr_cmd;
  hcfb_pkg::cmd_t q_cmd;

  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width <= hcfb_pkg::SCREEN_WIDTH_RESET;
      screen_height <= hcfb_pkg::SCREEN_HEIGHT_RESET;
    end else if (cfg_write) begin
      case (paddr)
        hcfb_pkg::REG_SCREEN_WIDTH: screen_width <= pwdata[15:0];
        hcfb_pkg::REG_SCREEN_HEIGHT: screen_height <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      hcfb_pkg::REG_SCREEN_WIDTH: prdata = {16'h0000, screen_width};
      hcfb_pkg::REG_SCREEN_HEIGHT: prdata = {16'h0000, screen_height};
      default: prdata = 32'h0000_0000;
    endcase
  end

  hcfb_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .func     (func),
    .buttons  (buttons),
    .key_0    (key_0),
    .key_1    (key_1),
    .key_2    (key_2),
    .key_3    (key_3),
    .key_4    (key_4),
    .key_5    (key_5),
    .pos_x    (pos_x),
    .pos_y    (pos_y),
    .wheel    (wheel),
    .q_ready  (q_ready),
    .push     (q_push),
    .cmd      (fr_cmd)
  );

  hcfb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (fr_cmd),
    .ready (q_ready),
    .pop   (q_pop),
    .valid (q_valid),
    .dout  (q_cmd)
  );

  hcfb_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_cmd         (q_cmd),
    .q_pop         (q_pop),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .frame_byte    (frame_byte),
    .last_byte     (last_byte)
  );

`ifndef SYNTHESIS
  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("Back stage took a command from an empty queue.");

  a_push_needs_space: assert property (@(posedge clk) disable iff (rst)
    q_push |-> q_ready)
    else $error("Front stage wrote into a full queue.");

  a_reset_clears_output: assert property (@(posedge clk)
    rst |=> !out_valid && !q_valid)
    else $error("Output or queue still valid after reset.");
`endif

endmodule

[rtl/core/hcfb_front.sv]
// Front stage: accepts requests, drops unused kinds and maps key codes to usages.
module hcfb_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        func,
  input  logic [7:0]        buttons,
  input  logic [7:0]        key_0,
  input  logic [7:0]        key_1,
  input  logic [7:0]        key_2,
  input  logic [7:0]        key_3,
  input  logic [7:0]        key_4,
  input  logic [7:0]        key_5,
  input  logic [15:0]       pos_x,
  input  logic [15:0]       pos_y,
  input  logic signed [7:0] wheel,
  input  logic              q_ready,
  output logic              push,
  output hcfb_pkg::cmd_t    cmd
);

  logic fr_valid;
  hcfb_pkg::cmd_t cmd_next;
  logic accept;

  assign push = fr_valid && q_ready;
  assign in_ready = !fr_valid || q_ready;
  assign accept = in_valid && in_ready;

  always_comb begin
    cmd_next.func = func;
    cmd_next.buttons = buttons;
    cmd_next.usage[0] = hcfb_pkg::key_usage(key_0);
    cmd_next.usage[1] = hcfb_pkg::key_usage(key_1);
    cmd_next.usage[2] = hcfb_pkg::key_usage(key_2);
    cmd_next.usage[3] = hcfb_pkg::key_usage(key_3);
    cmd_next.usage[4] = hcfb_pkg::key_usage(key_4);
    cmd_next.usage[5] = hcfb_pkg::key_usage(key_5);
    cmd_next.pos_x = pos_x;
    cmd_next.pos_y = pos_y;
    cmd_next.wheel = wheel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
    end else if (accept) begin
      fr_valid <= (func != hcfb_pkg::FUNC_NONE);
    end else if (push) begin
      fr_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= cmd_next;
    end
  end

endmodule

[rtl/core/hcfb_queue.sv]
// Small command queue between the front and back stages.
module hcfb_queue #(
  parameter int DEPTH = hcfb_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  hcfb_pkg::cmd_t din,
  output logic           ready,
  input  logic           pop,
  output logic           valid,
  output hcfb_pkg::cmd_t dout
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  hcfb_pkg::cmd_t mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign ready = (count != FULL_COUNT);
  assign valid = (count != '0);
  assign dout = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

[rtl/core/hcfb_div.sv]
// Radix-4 restoring divider that scales a position by 4096 over the screen size.
module hcfb_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [11:0] quot
);

  localparam int CNT_W = $clog2(hcfb_pkg::DIV_STEPS);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(hcfb_pkg::DIV_STEPS - 1);

  logic busy;
  logic sat;
  logic [CNT_W-1:0] cnt;
  logic [15:0] rem;
  logic [11:0] q;
  logic [16:0] r1;
  logic [15:0] r1s;
  logic [16:0] r2;
  logic [15:0] r2s;
  logic b1;
  logic b2;

  always_comb begin
    r1 = {rem, 1'b0};
    b1 = (r1 >= {1'b0, divisor});
    r1s = b1 ? 16'(r1 - {1'b0, divisor}) : r1[15:0];
    r2 = {r1s, 1'b0};
    b2 = (r2 >= {1'b0, divisor});
    r2s = b2 ? 16'(r2 - {1'b0, divisor}) : r2[15:0];
  end

  assign done = !busy;
  assign quot = sat ? 12'hFFF : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == LAST_STEP) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sat <= (dividend >= divisor);
      rem <= dividend;
      q <= '0;
    end else if (busy) begin
      rem <= r2s;
      q <= {q[9:0], b1, b2};
    end
  end

endmodule

[rtl/core/hcfb_back.sv]
// Back stage: serializes one command into frame bytes with a running checksum.
module hcfb_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  hcfb_pkg::cmd_t q_cmd,
  output logic           q_pop,
  input  logic [15:0]    screen_width,
  input  logic [15:0]    screen_height,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     frame_byte,
  output logic           last_byte
);

  hcfb_pkg::cmd_t cmd;
  logic busy;
  logic [3:0] idx;
  logic [7:0] sum;
  logic [3:0] len;
  logic is_last;
  logic [7:0] field_byte;
  logic [7:0] byte_out;
  logic avail;
  logic adv;
  logic emit;
  logic load;
  logic div_start;
  logic x_done;
  logic y_done;
  logic [11:0] x_val;
  logic [11:0] y_val;

  assign div_start = load && (q_cmd.func == hcfb_pkg::FUNC_ABS);

  hcfb_div u_div_x (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (q_cmd.pos_x),
    .divisor  (screen_width),
    .done     (x_done),
    .quot     (x_val)
  );

  hcfb_div u_div_y (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (q_cmd.pos_y),
    .divisor  (screen_height),
    .done     (y_done),
    .quot     (y_val)
  );

  always_comb begin
    case (cmd.func)
      hcfb_pkg::FUNC_KBD: len = hcfb_pkg::FRAME_LEN_KBD;
      hcfb_pkg::FUNC_REL: len = hcfb_pkg::FRAME_LEN_REL;
      default:            len = hcfb_pkg::FRAME_LEN_ABS;
    endcase
  end

  always_comb begin
    field_byte = 8'h00;
    case (idx)
      4'd0: field_byte = hcfb_pkg::SYNC_0;
      4'd1: field_byte = hcfb_pkg::SYNC_1;
      4'd2: field_byte = hcfb_pkg::ADDR_BYTE;
      default: begin
        case (cmd.func)
          hcfb_pkg::FUNC_KBD: begin
            case (idx)
              4'd3:  field_byte = hcfb_pkg::CMD_KBD;
              4'd4:  field_byte = hcfb_pkg::LEN_KBD;
              4'd5:  field_byte = cmd.buttons;
              4'd7:  field_byte = cmd.usage[0];
              4'd8:  field_byte = cmd.usage[1];
              4'd9:  field_byte = cmd.usage[2];
              4'd10: field_byte = cmd.usage[3];
              4'd11: field_byte = cmd.usage[4];
              4'd12: field_byte = cmd.usage[5];
              default: field_byte = 8'h00;
            endcase
          end
          hcfb_pkg::FUNC_REL: begin
            case (idx)
              4'd3: field_byte = hcfb_pkg::CMD_REL;
              4'd4: field_byte = hcfb_pkg::LEN_REL;
              4'd5: field_byte = hcfb_pkg::MODE_REL;
              4'd6: field_byte = cmd.buttons;
              4'd7: field_byte = cmd.pos_x[7:0];
              4'd8: field_byte = cmd.pos_y[7:0];
              4'd9: field_byte = cmd.wheel;
              default: field_byte = 8'h00;
            endcase
          end
          default: begin
            case (idx)
              4'd3:  field_byte = hcfb_pkg::CMD_ABS;
              4'd4:  field_byte = hcfb_pkg::LEN_ABS;
              4'd5:  field_byte = hcfb_pkg::MODE_ABS;
              4'd6:  field_byte = cmd.buttons;
              4'd7:  field_byte = x_val[7:0];
              4'd8:  field_byte = {4'h0, x_val[11:8]};
              4'd9:  field_byte = y_val[7:0];
              4'd10: field_byte = {4'h0, y_val[11:8]};
              4'd11: field_byte = cmd.wheel;
              default: field_byte = 8'h00;
            endcase
          end
        endcase
      end
    endcase
  end

  assign is_last = (idx == len - 4'd1);
  assign byte_out = is_last ? sum : field_byte;
  assign avail = busy && ((cmd.func != hcfb_pkg::FUNC_ABS) || (idx < 4'd7) ||
                          (x_done && y_done));
  assign adv = !out_valid || out_ready;
  assign emit = adv && avail;
  assign load = q_valid && (!busy || (emit && is_last));
  assign q_pop = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      out_valid <= 1'b0;
      idx <= '0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
        idx <= idx + 1'b1;
        if (is_last) begin
          busy <= 1'b0;
        end
      end else if (adv) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        busy <= 1'b1;
        idx <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      frame_byte <= byte_out;
      last_byte <= is_last;
      sum <= sum + byte_out;
    end
    if (load) begin
      cmd <= q_cmd;
      sum <= '0;
    end
  end

endmodule

[tb/sv/tb_hid_command_frame_builder_core.sv]
`timescale 1ns / 100ps
// Self-checking testbench of the HID command frame builder: directed table, random commands.
module tb_hid_command_frame_builder_core;

  localparam int CLK_HALF = 10;
  localparam int RESET_CYCLES = 9;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 32;
  localparam int IDLE_LIMIT = 20000;
  localparam int ITEMS_PER_PHASE = 70;
  localparam int PHASE_COUNT = 7;
  localparam int HOLD_AT_BYTE = 1500;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_REPORTS = 40;

  localparam logic [12:0][7:0] PUNCT_CHARS = {
    8'h30, 8'h20, 8'h2D, 8'h3D, 8'h5B, 8'h5D, 8'h5C,
    8'h3B, 8'h27, 8'h60, 8'h2C, 8'h2E, 8'h2F
  };

  typedef struct packed {
    logic [1:0]      func;
    logic [7:0]      buttons;
    logic [5:0][7:0] keys;
    logic [15:0]     pos_x;
    logic [15:0]     pos_y;
    logic [7:0]      wheel;
  } hid_cmd_t;

  typedef struct {
    hid_cmd_t         cmd;
    int               fixed_len;
    logic [0:13][7:0] fixed_bytes;
  } stim_row_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_beat_t;

  typedef enum int {RX_STEADY, RX_CHOPPY, RX_STALLY} rx_mode_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  func;
  logic [7:0]  buttons;
  logic [7:0]  key_0;
  logic [7:0]  key_1;
  logic [7:0]  key_2;
  logic [7:0]  key_3;
  logic [7:0]  key_4;
  logic [7:0]  key_5;
  logic [15:0] pos_x;
  logic [15:0] pos_y;
  logic [7:0]  wheel;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  frame_byte;
  logic        last_byte;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  logic [15:0] cur_width = hcfb_pkg::SCREEN_WIDTH_RESET;
  logic [15:0] cur_height = hcfb_pkg::SCREEN_HEIGHT_RESET;
  frame_beat_t pending_beats[$];
  frame_beat_t seen_beat;
  stim_row_t   stim_rows[$];
  bit          sender_burst;
  int          err_count = 0;
  int          cmd_count = 0;
  int          byte_count = 0;
  int          cfg_count = 0;
  int          cycle_count = 0;

  hid_command_frame_builder_core dut (.*);

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic logic [7:0] char_to_usage(input logic [7:0] c);
    logic [7:0] u;
    u = 8'h00;
    if (c >= 8'h41 && c <= 8'h5A) begin
      u = c - 8'h3D;
    end else if (c >= 8'h31 && c <= 8'h39) begin
      u = c - 8'h13;
    end else if (c >= 8'h21 && c <= 8'h24) begin
      u = c + 8'h07;
    end else if (c > 8'h60) begin
      u = c - 8'h28;
    end else begin
      case (c)
        8'h30: u = 8'h27;
        8'h20: u = 8'h2C;
        8'h2D: u = 8'h2D;
        8'h3D: u = 8'h2E;
        8'h5B: u = 8'h2F;
        8'h5D: u = 8'h30;
        8'h5C: u = 8'h31;
        8'h3B: u = 8'h33;
        8'h27: u = 8'h34;
        8'h60: u = 8'h35;
        8'h2C: u = 8'h36;
        8'h2E: u = 8'h37;
        8'h2F: u = 8'h38;
        default: u = 8'h00;
      endcase
    end
    return u;
  endfunction

  function automatic logic [15:0] scale_coord(input logic [15:0] pos, input logic [15:0] size);
    logic [31:0] q;
    if (size == 16'd0) return 16'd4095;
    q = (32'd4096 * {16'd0, pos}) / {16'd0, size};
    return (q > 32'd4095) ? 16'd4095 : q[15:0];
  endfunction

  function automatic void predict_frame(input hid_cmd_t c);
    logic [7:0]  fb [14];
    logic [7:0]  sum;
    logic [15:0] ax;
    logic [15:0] ay;
    int          n;
    fb[0] = hcfb_pkg::SYNC_0;
    fb[1] = hcfb_pkg::SYNC_1;
    fb[2] = hcfb_pkg::ADDR_BYTE;
    ax = scale_coord(c.pos_x, cur_width);
    ay = scale_coord(c.pos_y, cur_height);
    case (c.func)
      hcfb_pkg::FUNC_KBD: begin
        fb[3] = hcfb_pkg::CMD_KBD;
        fb[4] = hcfb_pkg::LEN_KBD;
        fb[5] = c.buttons;
        fb[6] = 8'h00;
        for (int i = 0; i < hcfb_pkg::KEY_COUNT; i++) fb[7 + i] = char_to_usage(c.keys[i]);
        n = int'(hcfb_pkg::FRAME_LEN_KBD);
      end
      hcfb_pkg::FUNC_REL: begin
        fb[3] = hcfb_pkg::CMD_REL;
        fb[4] = hcfb_pkg::LEN_REL;
        fb[5] = hcfb_pkg::MODE_REL;
        fb[6] = c.buttons;
        fb[7] = c.pos_x[7:0];
        fb[8] = c.pos_y[7:0];
        fb[9] = c.wheel;
        n = int'(hcfb_pkg::FRAME_LEN_REL);
      end
      hcfb_pkg::FUNC_ABS: begin
        fb[3] = hcfb_pkg::CMD_ABS;
        fb[4] = hcfb_pkg::LEN_ABS;
        fb[5] = hcfb_pkg::MODE_ABS;
        fb[6] = c.buttons;
        fb[7] = ax[7:0];
        fb[8] = ax[15:8];
        fb[9] = ay[7:0];
        fb[10] = ay[15:8];
        fb[11] = c.wheel;
        n = int'(hcfb_pkg::FRAME_LEN_ABS);
      end
      default: return;
    endcase
    sum = 8'h00;
    for (int i = 0; i < n - 1; i++) begin
      sum += fb[i];
      pending_beats.push_back(frame_beat_t'{fb[i], 1'b0});
    end
    pending_beats.push_back(frame_beat_t'{sum, 1'b1});
  endfunction

  function automatic int pos_span(input logic [15:0] size);
    int s;
    if (size == 16'd0) return 65535;
    s = size + size / 8;
    return (s > 65535) ? 65535 : s;
  endfunction

  function automatic hid_cmd_t random_cmd();
    hid_cmd_t c;
    int       r;
    r = $urandom_range(0, 99);
    c.func = (r < 30) ? hcfb_pkg::FUNC_KBD : (r < 60) ? hcfb_pkg::FUNC_REL :
             (r < 92) ? hcfb_pkg::FUNC_ABS : hcfb_pkg::FUNC_NONE;
    c.buttons = 8'($urandom);
    for (int i = 0; i < hcfb_pkg::KEY_COUNT; i++) begin
      if ($urandom_range(0, 1) == 0) begin
        c.keys[i] = 8'($urandom);
      end else begin
        case ($urandom_range(0, 4))
          0: c.keys[i] = 8'($urandom_range(8'h21, 8'h24));
          1: c.keys[i] = 8'($urandom_range(8'h41, 8'h5A));
          2: c.keys[i] = 8'($urandom_range(8'h31, 8'h39));
          3: c.keys[i] = 8'($urandom_range(8'h61, 8'hFF));
          default: c.keys[i] = PUNCT_CHARS[4'($urandom_range(0, 12))];
        endcase
      end
    end
    c.pos_x = 16'($urandom);
    c.pos_y = 16'($urandom);
    if (c.func == hcfb_pkg::FUNC_ABS && $urandom_range(0, 3) != 0) begin
      c.pos_x = 16'($urandom_range(0, pos_span(cur_width)));
      c.pos_y = 16'($urandom_range(0, pos_span(cur_height)));
    end
    c.wheel = 8'($urandom);
    return c;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_count++;
    if (err_count <= MAX_REPORTS) begin
      $display("mismatch: %s got 0x%0h expected 0x%0h at cycle %0d",
               what, got, want, cycle_count);
    end
  endtask

  task automatic add_row(input logic [1:0] f, input logic [7:0] b, input logic [5:0][7:0] k,
                         input logic [15:0] x, input logic [15:0] y, input logic [7:0] w,
                         input int flen, input logic [0:13][7:0] fbytes);
    stim_row_t row;
    row.cmd = '{f, b, k, x, y, w};
    row.fixed_len = flen;
    row.fixed_bytes = fbytes;
    stim_rows.push_back(row);
  endtask

  task automatic send_cmd(input hid_cmd_t c, input int flen, input logic [0:13][7:0] fbytes);
    int gap;
    int r;
    gap = 0;
    if (!sender_burst) begin
      r = $urandom_range(0, 99);
      if (r >= 90) gap = $urandom_range(8, 40);
      else if (r >= 60) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    func <= c.func;
    buttons <= c.buttons;
    key_0 <= c.keys[0];
    key_1 <= c.keys[1];
    key_2 <= c.keys[2];
    key_3 <= c.keys[3];
    key_4 <= c.keys[4];
    key_5 <= c.keys[5];
    pos_x <= c.pos_x;
    pos_y <= c.pos_y;
    wheel <= c.wheel;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    cmd_count++;
    if (flen < 0) begin
      predict_frame(c);
    end else begin
      for (int i = 0; i < flen; i++) begin
        pending_beats.push_back(frame_beat_t'{fbytes[i], i == flen - 1});
      end
    end
  endtask

  task automatic wait_idle();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (pending_beats.size() != 0 && waited < IDLE_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_beats.size() != 0) begin
      report_mismatch("frame bytes never delivered", pending_beats.size(), 0);
      pending_beats.delete();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_screen_regs(input logic [15:0] w, input logic [15:0] h);
    logic [31:0] rd;
    apb_access(1'b0, hcfb_pkg::REG_SCREEN_WIDTH, 32'd0, rd);
    if (rd !== {16'd0, w}) report_mismatch("screen width readback", rd, {16'd0, w});
    apb_access(1'b0, hcfb_pkg::REG_SCREEN_HEIGHT, 32'd0, rd);
    if (rd !== {16'd0, h}) report_mismatch("screen height readback", rd, {16'd0, h});
  endtask

  task automatic set_screen(input logic [15:0] w, input logic [15:0] h);
    logic [31:0] rd;
    apb_access(1'b1, hcfb_pkg::REG_SCREEN_WIDTH, {16'd0, w}, rd);
    apb_access(1'b1, hcfb_pkg::REG_SCREEN_HEIGHT, {16'd0, h}, rd);
    cur_width = w;
    cur_height = h;
    cfg_count++;
    check_screen_regs(w, h);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      byte_count++;
      if (pending_beats.size() == 0) begin
        report_mismatch("unexpected frame byte", 32'(frame_byte), 0);
      end else begin
        seen_beat = pending_beats.pop_front();
        if (frame_byte !== seen_beat.data) begin
          report_mismatch("frame_byte", 32'(frame_byte), 32'(seen_beat.data));
        end
        if (last_byte !== seen_beat.last) begin
          report_mismatch("last_byte", 32'(last_byte), 32'(seen_beat.last));
        end
      end
    end
  end

  // The receiver mixes ready modes and holds off once for a long stretch to fill the queue.
  initial begin
    rx_mode_t mode;
    int       mode_left;
    int       stall_left;
    bit       held;
    mode = RX_STEADY;
    mode_left = 0;
    stall_left = 0;
    held = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held && byte_count >= HOLD_AT_BYTE) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (mode_left == 0) begin
        mode = rx_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(50, 300);
      end
      mode_left--;
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          RX_STEADY: out_ready <= 1'b1;
          RX_CHOPPY: out_ready <= ($urandom_range(0, 3) != 0);
          default: begin
            if ($urandom_range(0, 99) < 4) begin
              stall_left = $urandom_range(8, 40);
              out_ready <= 1'b0;
            end else begin
              out_ready <= 1'b1;
            end
          end
        endcase
      end
    end
  end

  initial begin
    logic [15:0] w;
    logic [15:0] h;
    rst <= 1'b1;
    in_valid <= 1'b0;
    func <= hcfb_pkg::FUNC_KBD;
    buttons <= 8'h00;
    key_0 <= 8'h00;
    key_1 <= 8'h00;
    key_2 <= 8'h00;
    key_3 <= 8'h00;
    key_4 <= 8'h00;
    key_5 <= 8'h00;
    pos_x <= 16'h0000;
    pos_y <= 16'h0000;
    wheel <= 8'h00;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= 3'd0;
    pwdata <= 32'd0;
    sender_burst = 1'b0;

    add_row(hcfb_pkg::FUNC_NONE, 8'h00, '0, 16'h0000, 16'h0000, 8'h00, 0, '0);
    add_row(hcfb_pkg::FUNC_KBD, 8'h00, '0, 16'h0000, 16'h0000, 8'h00, 14,
            {8'h57, 8'hAB, 8'h00, 8'h02, 8'h08, 8'h00, 8'h00,
             8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h0C});
    add_row(hcfb_pkg::FUNC_REL, 8'h00, '0, 16'h0000, 16'h0000, 8'h00, 11,
            {8'h57, 8'hAB, 8'h00, 8'h05, 8'h05, 8'h01, 8'h00,
             8'h00, 8'h00, 8'h00, 8'h0D, 8'h00, 8'h00, 8'h00});
    add_row(hcfb_pkg::FUNC_ABS, 8'h00, '0, 16'h0000, 16'h0000, 8'h00, 13,
            {8'h57, 8'hAB, 8'h00, 8'h04, 8'h07, 8'h02, 8'h00,
             8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h0F, 8'h00});
    add_row(hcfb_pkg::FUNC_ABS, 8'h00, '0, 16'hFFFF, 16'hFFFF, 8'h00, 13,
            {8'h57, 8'hAB, 8'h00, 8'h04, 8'h07, 8'h02, 8'h00,
             8'hFF, 8'h0F, 8'hFF, 8'h0F, 8'h00, 8'h2B, 8'h00});
    add_row(hcfb_pkg::FUNC_KBD, 8'hFF, {8'h39, 8'h31, 8'h5A, 8'h41, 8'h24, 8'h21},
            16'hFFFF, 16'hFFFF, 8'hFF, -1, '0);
    add_row(hcfb_pkg::FUNC_KBD, 8'hA5, {8'h3D, 8'h2D, 8'h20, 8'h30, 8'hFF, 8'h61},
            16'h0000, 16'h0000, 8'h00, -1, '0);
    add_row(hcfb_pkg::FUNC_KBD, 8'h5A, {8'h60, 8'h27, 8'h3B, 8'h5C, 8'h5D, 8'h5B},
            16'h1234, 16'h5678, 8'h80, -1, '0);
    add_row(hcfb_pkg::FUNC_KBD, 8'h01, {8'h25, 8'h40, 8'h60, 8'h2F, 8'h2E, 8'h2C},
            16'h0000, 16'h0000, 8'h00, -1, '0);
    add_row(hcfb_pkg::FUNC_KBD, 8'h80, {8'h5F, 8'h5E, 8'h3C, 8'h3A, 8'h00, 8'h1F},
            16'h0000, 16'h0000, 8'h00, -1, '0);
    add_row(hcfb_pkg::FUNC_KBD, 8'h00, {6{8'hFF}}, 16'h0000, 16'h0000, 8'h00, -1, '0);
    add_row(hcfb_pkg::FUNC_REL, 8'hFF, {6{8'hFF}}, 16'hFFFF, 16'h8000, 8'h80, -1, '0);
    add_row(hcfb_pkg::FUNC_REL, 8'h55, '0, 16'h007F, 16'h0080, 8'h7F, -1, '0);
    add_row(hcfb_pkg::FUNC_ABS, 8'h01, '0, 16'd1919, 16'd1079, 8'hFF, -1, '0);
    add_row(hcfb_pkg::FUNC_ABS, 8'h02, '0, 16'd1920, 16'd1080, 8'h01, -1, '0);
    add_row(hcfb_pkg::FUNC_ABS, 8'hFF, {6{8'hAA}}, 16'd960, 16'd540, 8'h80, -1, '0);
    add_row(hcfb_pkg::FUNC_ABS, 8'h00, '0, 16'd1, 16'd1, 8'h7F, -1, '0);
    add_row(hcfb_pkg::FUNC_NONE, 8'hFF, {6{8'hFF}}, 16'hFFFF, 16'hFFFF, 8'hFF, 0, '0);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    check_screen_regs(hcfb_pkg::SCREEN_WIDTH_RESET, hcfb_pkg::SCREEN_HEIGHT_RESET);

    foreach (stim_rows[i]) send_cmd(stim_rows[i].cmd, stim_rows[i].fixed_len,
                                    stim_rows[i].fixed_bytes);

    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0: begin w = 16'd1; h = 16'd1; end
        1: begin w = 16'hFFFF; h = 16'hFFFF; end
        2: begin w = 16'd0; h = 16'd0; end
        3: begin w = 16'd3; h = 16'hFFFF; end
        6: begin w = hcfb_pkg::SCREEN_WIDTH_RESET; h = hcfb_pkg::SCREEN_HEIGHT_RESET; end
        default: begin
          w = 16'($urandom_range(1, 65535));
          h = 16'($urandom_range(1, 65535));
        end
      endcase
      wait_idle();
      set_screen(w, h);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 32 == 0) sender_burst = ($urandom_range(0, 99) < 30);
        send_cmd(random_cmd(), -1, '0);
      end
    end

    wait_idle();
    $display("run covered %0d commands, %0d frame bytes and %0d screen settings",
             cmd_count, byte_count, cfg_count + 1);
    $display("with %0d mismatches", err_count);
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/hcfb_pkg.sv
rtl/core/hcfb_front.sv
rtl/core/hcfb_queue.sv
rtl/core/hcfb_div.sv
rtl/core/hcfb_back.sv
rtl/core/hid_command_frame_builder_core.sv
tb/sv/tb_hid_command_frame_builder_core.sv
